// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SKF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W  = 32;
    localparam int GAIN_W  = FRACTION_BITS + 1;
    localparam int DENOM_W = DATA_W + 1;
    localparam int REM_W   = DATA_W + 2;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int CNT_W   = $clog2(FRACTION_BITS + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRACTION_BITS;
    localparam logic [PROD_W-1:0] HALF_Q   = PROD_W'(1) << (FRACTION_BITS - 1);

    localparam logic [DATA_W-1:0] RESET_MEAS_ERR   = 32'd131072;
    localparam logic [DATA_W-1:0] RESET_EST_ERR    = 32'd131072;
    localparam logic [DATA_W-1:0] RESET_PROC_NOISE = 32'd655;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EST_ERR_INIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MUL_GAIN,
        ST_CHANGE,
        ST_MUL_T1,
        ST_MUL_T2,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_GAIN,
        MUL_T1,
        MUL_T2
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    div_first;
        mul_op_t mul_op;
        logic    change_en;
        logic    finish;
    } cmd_t;

    // sample moved to fixed point, saturated to the data width
    function automatic logic [DATA_W-1:0] sample_to_q(input logic [SAMPLE_BITS-1:0] s);
        logic [PROD_W-1:0] w;
        begin
            w = PROD_W'(s) << FRACTION_BITS;
            if (|w[PROD_W-1:DATA_W])
            begin
                sample_to_q = '1;
            end
            else
            begin
                sample_to_q = w[DATA_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/skf_ctrl.sv -----
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer: divider steps, shared multiplier passes, result register valid.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl
    import skf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output cmd_t      cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '{load: 1'b0, div_step: 1'b0, div_first: 1'b0, mul_op: MUL_NONE,
                       change_en: 1'b0, finish: 1'b0};
        // result leaves on a transfer
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(FRACTION_BITS))
                begin
                    state_next = ST_MUL_GAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_op = MUL_GAIN;
                state_next = ST_CHANGE;
            end
            ST_CHANGE:
            begin
                cmd.change_en = 1'b1;
                state_next    = ST_MUL_T1;
            end
            ST_MUL_T1:
            begin
                cmd.mul_op = MUL_T1;
                state_next = ST_MUL_T2;
            end
            ST_MUL_T2:
            begin
                cmd.mul_op = MUL_T2;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/skf_datapath.sv -----
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, configuration registers, restoring divider, shared multiplier
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_datapath
    import skf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data,
    output logic      [DATA_W-1:0]      estimate,
    output logic      [GAIN_W-1:0]      gain,
    output logic      [DATA_W-1:0]      estimate_uncertainty
);

    // state and configuration
    logic [DATA_W-1:0] meas_reg, meas_next;
    logic [DATA_W-1:0] noise_reg, noise_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic [DATA_W-1:0] err_reg, err_next;

    // per-item working registers
    logic [DENOM_W-1:0] denom_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [GAIN_W-1:0]  quo_reg;
    logic               dir_reg;
    logic [DATA_W-1:0]  mag_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DATA_W-1:0]  change_reg;
    logic [DATA_W-1:0]  est_reg;
    logic [DATA_W-1:0]  t1_reg;
    logic [DATA_W-1:0]  est_out_reg;
    logic [GAIN_W-1:0]  gain_out_reg;
    logic [DATA_W-1:0]  unc_out_reg;

    logic [DATA_W-1:0]   sample_q;
    logic                up;
    logic [REM_W-1:0]    trial;
    logic                trial_ge;
    logic [GAIN_W-1:0]   gain_w;
    logic [DATA_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   rounded;
    logic [PROD_W-1:0]   change_wide;
    logic [DATA_W-1:0]   change_w;
    logic [PROD_W:0]     err_sum;
    logic [DATA_W-1:0]   new_err;

    assign sample_q = sample_to_q(sample);
    assign up       = (sample_q >= last_reg);

    // one quotient bit per step; the first step takes the remainder unshifted
    assign trial    = cmd.div_first ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign trial_ge = (trial >= REM_W'(denom_reg));

    // both errors zero gives gain zero
    assign gain_w = (denom_reg == '0) ? '0 : quo_reg;

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_GAIN:
            begin
                mul_a = DATA_W'(gain_w);
                mul_b = mag_reg;
            end
            MUL_T1:
            begin
                mul_a = DATA_W'(GAIN_ONE - gain_w);
                mul_b = err_reg;
            end
            MUL_T2:
            begin
                mul_a = change_reg;
                mul_b = noise_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // round half up, never step past the sample
    assign rounded     = prod_reg + HALF_Q;
    assign change_wide = rounded >> FRACTION_BITS;
    assign change_w    = (change_wide > PROD_W'(mag_reg)) ? mag_reg : change_wide[DATA_W-1:0];

    assign err_sum = (PROD_W + 1)'(prod_reg >> FRACTION_BITS) + (PROD_W + 1)'(t1_reg);
    assign new_err = (|err_sum[PROD_W:DATA_W]) ? '1 : err_sum[DATA_W-1:0];

    always_comb
    begin
        meas_next  = meas_reg;
        noise_next = noise_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (cmd.finish)
        begin
            last_next = est_reg;
            err_next  = new_err;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MEAS_ERR:     meas_next  = cfg_data;
                CFG_EST_ERR_INIT: err_next   = cfg_data;
                CFG_PROC_NOISE:   noise_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_reg  <= RESET_MEAS_ERR;
            noise_reg <= RESET_PROC_NOISE;
            last_reg  <= '0;
            err_reg   <= RESET_EST_ERR;
        end
        else
        begin
            meas_reg  <= meas_next;
            noise_reg <= noise_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            denom_reg <= DENOM_W'(err_reg) + DENOM_W'(meas_reg);
            rem_reg   <= REM_W'(err_reg);
            quo_reg   <= '0;
            dir_reg   <= up;
            mag_reg   <= up ? (sample_q - last_reg) : (last_reg - sample_q);
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? (trial - REM_W'(denom_reg)) : trial;
            quo_reg <= {quo_reg[GAIN_W-2:0], trial_ge};
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= product;
        end
        if (cmd.change_en)
        begin
            change_reg <= change_w;
        end
        if (cmd.mul_op == MUL_T1)
        begin
            est_reg <= dir_reg ? (last_reg + change_reg) : (last_reg - change_reg);
        end
        if (cmd.mul_op == MUL_T2)
        begin
            // product register still holds (1 - gain) * err here
            t1_reg <= prod_reg[FRACTION_BITS +: DATA_W];
        end
        if (cmd.finish)
        begin
            est_out_reg  <= est_reg;
            gain_out_reg <= gain_w;
            unc_out_reg  <= new_err;
        end
    end

    assign estimate             = est_out_reg;
    assign gain                 = gain_out_reg;
    assign estimate_uncertainty = unc_out_reg;

endmodule

`default_nettype wire

// ----- rtl/scalar_kalman_smoother.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_smoother
// One-dimensional fixed-point Kalman smoother for unsigned sensor samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: the restoring divider forms the gain
// one quotient bit per cycle, then three passes run through the shared 32x32
// multiplier with the rounding of the estimate step between the first two, and
// a last step sums the new error and loads the result register. The next
// sample is taken the cycle after that load; a result left waiting in the
// register holds the following item in its last cycle.
// Estimate and error are Q16.16, gain Q1.16; after reset the stored estimate is
// zero, the running error 2.0, measurement error 2.0 and process noise 655.
// Writing the estimate error register reloads the running error.
`default_nettype none

module scalar_kalman_smoother
    import skf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [DATA_W-1:0]      estimate,
    output logic      [GAIN_W-1:0]      gain,
    output logic      [DATA_W-1:0]      estimate_uncertainty,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data
);

    cmd_t cmd;

    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    skf_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sample               (sample),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .estimate             (estimate),
        .gain                 (gain),
        .estimate_uncertainty (estimate_uncertainty)
    );

endmodule

`default_nettype wire

// ----- rtl/skf_checker.sv -----
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks on the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module skf_checker
    import skf_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [DATA_W-1:0]      estimate,
    input wire logic [GAIN_W-1:0]      gain,
    input wire logic [DATA_W-1:0]      estimate_uncertainty
);

    // gain never passes one
    `SKF_ASSERT_SAME(a_gain_max, out_valid, gain <= GAIN_ONE, "gain above one")

    // a sample transfer makes the block busy
    `SKF_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input not stalled")

    // a new result only appears while the block was busy with a sample
    `SKF_ASSERT_SAME(a_result_source, $rose(out_valid), $past(in_stall), "result without a sample")

    // a stalled result holds its estimate and uncertainty
    `SKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(estimate) && $stable(estimate_uncertainty), "stalled result moved")

endmodule

bind scalar_kalman_smoother skf_checker u_skf_checker (.*);

`default_nettype wire
